// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; every macro expects signals named clock and reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent must hold whenever the antecedent holds
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rsmp_pkg.sv =====
// shared types and constants of the polyline density resampler
// no dependencies
`default_nettype none

package rsmp_pkg;

   localparam int POS_N      = 3;
   localparam int COL_N      = 4;
   localparam int CH_N       = POS_N + COL_N;
   localparam int POS_W      = 32;
   localparam int COL_W      = 16;
   localparam int DENS_W     = 24;
   localparam int CH_W       = 34;
   localparam int MAG_W      = 32;
   localparam int CMDQ_DEPTH = 2;

   localparam logic [DENS_W-1:0] DENSITY_RESET = 24'd65536;

   typedef enum logic {
      CMD_VERTEX,
      CMD_SEGMENT
   } cmd_kind_type;

   typedef struct packed {
      logic [POS_N-1:0][POS_W-1:0] pos;
      logic [COL_N-1:0][COL_W-1:0] col;
   } vertex_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         fin;
      vertex_type   cur;
      vertex_type   prev;
   } cmd_type;

   typedef struct packed {
      vertex_type pt;
      logic       run_end;
      logic       line_end;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/rsmp_front.sv =====
// front end: accepts vertices, keeps the previous vertex, classifies each transaction
// depends on rsmp_pkg
`default_nettype none

module rsmp_front import rsmp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire logic       q_full,
   input  wire vertex_type vtx,
   input  wire logic       fin,
   input  wire logic       density_zero,
   output logic            q_push,
   output cmd_type         q_cmd
);

   vertex_type prev_ff, prev_in;
   logic       have_prev_ff, have_prev_in;
   logic       accept;

   assign accept = push && !q_full;

   always_comb begin
      prev_in         = prev_ff;
      have_prev_in    = have_prev_ff;
      q_push          = 1'b0;
      q_cmd.kind      = CMD_VERTEX;
      q_cmd.fin       = fin;
      q_cmd.cur       = vtx;
      q_cmd.prev      = prev_ff;
      if (accept) begin
         if (density_zero) begin
            q_push       = 1'b1;
            prev_in      = vtx;
            have_prev_in = !fin;
         end else if (!have_prev_ff) begin
            if (fin) begin
               q_push = 1'b1;
            end else begin
               prev_in      = vtx;
               have_prev_in = 1'b1;
            end
         end else begin
            q_push       = 1'b1;
            q_cmd.kind   = CMD_SEGMENT;
            prev_in      = vtx;
            have_prev_in = !fin;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rsmp_cmdq.sv =====
// short command queue between front and back ends
// depends on rsmp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rsmp_cmdq import rsmp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type wdata,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      rdata,
   output logic         empty
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type             mem [CMDQ_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPLIES(a_no_lost_push, push, !full, "command pushed into full queue")

endmodule

`default_nettype wire

// ===== rtl/rsmp_gap.sv =====
// gap counter: exact ceil(distance * density) saturated at the gap limit
// depends on rsmp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rsmp_gap import rsmp_pkg::*; #(
   parameter int MAX_GAPS = 63,
   parameter int NW       = $clog2(MAX_GAPS + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [POS_N-1:0][MAG_W-1:0] mag,
   input  wire logic [DENS_W-1:0]           density,
   output logic                             done,
   output logic [NW-1:0]                    gaps
);

   localparam int SQ_W  = 2 * MAG_W;
   localparam int S_W   = SQ_W + 2;
   localparam int E_W   = 2 * DENS_W;
   localparam int ACC_W = S_W + E_W;
   localparam int SC_W  = S_W / 3;
   localparam int EC_W  = E_W / 2;
   localparam int PP_W  = SC_W + EC_W;
   localparam int T_W   = ACC_W - 64 + 1;
   localparam int BW    = (NW > 1) ? $clog2(NW) : 1;

   typedef enum logic [2:0] {
      G_IDLE, G_SQUARE, G_SUM, G_MUL, G_TERM, G_ROOT, G_DONE
   } gstate_type;

   gstate_type          state_ff, state_in;
   logic [SQ_W-1:0]     sq_ff [POS_N];
   logic [SQ_W-1:0]     sq_in [POS_N];
   logic [E_W-1:0]      e_ff, e_in;
   logic [S_W-1:0]      s_ff, s_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [1:0]          sc_ff, sc_in;
   logic                ec_ff, ec_in;
   logic [T_W-1:0]      t_ff, t_in;
   logic [NW-1:0]       root_ff, root_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic                done_ff, done_in;
   logic [NW-1:0]       gaps_ff, gaps_in;
   logic [PP_W-1:0]     pp;
   logic [NW-1:0]       cand;
   logic [2*NW-1:0]     cand_sq;
   logic [NW:0]         root_inc;

   assign pp      = s_ff[32'(sc_ff) * SC_W +: SC_W] * e_ff[32'(ec_ff) * EC_W +: EC_W];
   assign cand    = root_ff | (NW'(1) << bit_ff);
   assign cand_sq = (2 * NW)'(cand) * (2 * NW)'(cand);
   assign root_inc = {1'b0, root_ff} + 1'b1;

   always_comb begin
      state_in = state_ff;
      sq_in    = sq_ff;
      e_in     = e_ff;
      s_in     = s_ff;
      acc_in   = acc_ff;
      sc_in    = sc_ff;
      ec_in    = ec_ff;
      t_in     = t_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      done_in  = 1'b0;
      gaps_in  = gaps_ff;
      unique case (state_ff)
         G_IDLE: begin
            if (start) begin
               state_in = G_SQUARE;
            end
         end
         G_SQUARE: begin
            for (int j = 0; j < POS_N; j++) begin
               sq_in[j] = SQ_W'(mag[j]) * SQ_W'(mag[j]);
            end
            e_in     = E_W'(density) * E_W'(density);
            state_in = G_SUM;
         end
         G_SUM: begin
            s_in     = S_W'(sq_ff[0]) + S_W'(sq_ff[1]) + S_W'(sq_ff[2]);
            acc_in   = '0;
            sc_in    = '0;
            ec_in    = 1'b0;
            state_in = G_MUL;
         end
         G_MUL: begin
            // one 22x24 partial product per cycle
            acc_in = acc_ff + (ACC_W'(pp) << (32'(sc_ff) * SC_W + 32'(ec_ff) * EC_W));
            if (sc_ff == 2'd2) begin
               sc_in = '0;
               ec_in = 1'b1;
               if (ec_ff) begin
                  state_in = G_TERM;
               end
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         G_TERM: begin
            // smallest n with n*n >= t
            t_in     = T_W'(acc_ff[ACC_W-1:64]) + T_W'(|acc_ff[63:0]);
            root_in  = '0;
            bit_in   = BW'(NW - 1);
            state_in = G_ROOT;
         end
         G_ROOT: begin
            if (T_W'(cand_sq) < t_ff) begin
               root_in = cand;
            end
            if (bit_ff == '0) begin
               state_in = G_DONE;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         G_DONE: begin
            done_in = 1'b1;
            if (t_ff == '0) begin
               gaps_in = '0;
            end else if (root_inc > (NW + 1)'(MAX_GAPS)) begin
               gaps_in = NW'(MAX_GAPS);
            end else begin
               gaps_in = root_inc[NW-1:0];
            end
            state_in = G_IDLE;
         end
         default: state_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      sq_ff   <= sq_in;
      e_ff    <= e_in;
      s_ff    <= s_in;
      acc_ff  <= acc_in;
      sc_ff   <= sc_in;
      ec_ff   <= ec_in;
      t_ff    <= t_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      gaps_ff <= gaps_in;
   end

   assign done = done_ff;
   assign gaps = gaps_ff;

   `ASSERT_IMPLIES(a_gap_limit, done_ff, gaps_ff <= NW'(MAX_GAPS), "gap count above limit")

endmodule

`default_nettype wire

// ===== rtl/rsmp_back.sv =====
// back end: divides segment deltas, steps the interpolation, holds the result register
// depends on rsmp_pkg, rsmp_gap and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module rsmp_back import rsmp_pkg::*; #(
   parameter int MAX_GAPS = 63
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire cmd_type           q_cmd,
   output logic                   q_pop,
   input  wire logic [DENS_W-1:0] density,
   input  wire logic              rsp_pop,
   output logic                   rsp_valid,
   output rsp_type                rsp
);

   localparam int NW        = $clog2(MAX_GAPS + 1);
   localparam int DIV_STEPS = MAG_W / 2;
   localparam int DC_W      = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      B_IDLE, B_START, B_GAP, B_DIV, B_FIX, B_POINT, B_VERTEX
   } bstate_type;

   bstate_type              state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [NW-1:0]           n_ff, n_in;
   logic [NW-1:0]           i_ff, i_in;
   logic [DC_W-1:0]         dcnt_ff, dcnt_in;
   logic [MAG_W-1:0]        dq_ff [CH_N];
   logic [MAG_W-1:0]        dq_in [CH_N];
   logic [NW-1:0]           dr_ff [CH_N];
   logic [NW-1:0]           dr_in [CH_N];
   logic signed [CH_W-1:0]  qa_ff [CH_N];
   logic signed [CH_W-1:0]  qa_in [CH_N];
   logic [NW-1:0]           ra_ff [CH_N];
   logic [NW-1:0]           ra_in [CH_N];
   logic signed [CH_W-1:0]  pt_ff [CH_N];
   logic signed [CH_W-1:0]  pt_in [CH_N];
   logic [NW-1:0]           r_ff [CH_N];
   logic [NW-1:0]           r_in [CH_N];
   logic                    ov_ff, ov_in;
   rsp_type                 rsp_ff, rsp_in;

   logic signed [CH_W-1:0]  cur_w [CH_N];
   logic signed [CH_W-1:0]  prv_w [CH_N];
   logic signed [CH_W-1:0]  diff [CH_N];
   logic [MAG_W-1:0]        mag [CH_N];
   logic [POS_N-1:0][MAG_W-1:0] gap_mag;
   logic                    gap_start, gap_done;
   logic [NW-1:0]           gaps;
   logic                    slot_free, last_pt;
   logic [NW:0]             r_sum;
   logic [NW:0]             div_t;
   logic [MAG_W-1:0]        div_q;
   logic [NW-1:0]           div_r;

   always_comb begin
      for (int j = 0; j < POS_N; j++) begin
         cur_w[j] = {{(CH_W - POS_W){cmd_ff.cur.pos[j][POS_W-1]}}, cmd_ff.cur.pos[j]};
         prv_w[j] = {{(CH_W - POS_W){cmd_ff.prev.pos[j][POS_W-1]}}, cmd_ff.prev.pos[j]};
      end
      for (int k = 0; k < COL_N; k++) begin
         cur_w[POS_N+k] = {{(CH_W - COL_W){1'b0}}, cmd_ff.cur.col[k]};
         prv_w[POS_N+k] = {{(CH_W - COL_W){1'b0}}, cmd_ff.prev.col[k]};
      end
      for (int j = 0; j < CH_N; j++) begin
         diff[j] = cur_w[j] - prv_w[j];
         mag[j]  = diff[j][CH_W-1] ? MAG_W'(-diff[j]) : MAG_W'(diff[j]);
      end
      for (int j = 0; j < POS_N; j++) begin
         gap_mag[j] = mag[j];
      end
   end

   assign gap_start = (state_ff == B_START) && (cmd_ff.kind == CMD_SEGMENT);

   rsmp_gap #(
      .MAX_GAPS (MAX_GAPS)
   ) u_gap (
      .clock   (clock),
      .reset   (reset),
      .start   (gap_start),
      .mag     (gap_mag),
      .density (density),
      .done    (gap_done),
      .gaps    (gaps)
   );

   assign slot_free = !ov_ff || rsp_pop;
   assign last_pt   = ({1'b0, i_ff} + 1'b1) == {1'b0, n_ff};
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      dcnt_in  = dcnt_ff;
      dq_in    = dq_ff;
      dr_in    = dr_ff;
      qa_in    = qa_ff;
      ra_in    = ra_ff;
      pt_in    = pt_ff;
      r_in     = r_ff;
      ov_in    = ov_ff && !rsp_pop;
      rsp_in   = rsp_ff;
      r_sum    = '0;
      div_t    = '0;
      div_q    = '0;
      div_r    = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               cmd_in   = q_cmd;
               state_in = B_START;
            end
         end
         B_START: begin
            state_in = (cmd_ff.kind == CMD_SEGMENT) ? B_GAP : B_VERTEX;
         end
         B_GAP: begin
            if (gap_done) begin
               n_in = gaps;
               if (gaps == '0) begin
                  state_in = cmd_ff.fin ? B_VERTEX : B_IDLE;
               end else begin
                  for (int j = 0; j < CH_N; j++) begin
                     dq_in[j] = mag[j];
                     dr_in[j] = '0;
                  end
                  dcnt_in  = '0;
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            // restoring division, two quotient bits per cycle
            for (int j = 0; j < CH_N; j++) begin
               div_q = dq_ff[j];
               div_r = dr_ff[j];
               for (int b = 0; b < 2; b++) begin
                  div_t = {div_r, div_q[MAG_W-1]};
                  div_q = {div_q[MAG_W-2:0], 1'b0};
                  if (div_t >= {1'b0, n_ff}) begin
                     div_t    = div_t - {1'b0, n_ff};
                     div_q[0] = 1'b1;
                  end
                  div_r = div_t[NW-1:0];
               end
               dq_in[j] = div_q;
               dr_in[j] = div_r;
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DC_W'(DIV_STEPS - 1)) begin
               state_in = B_FIX;
            end
         end
         B_FIX: begin
            // floor division for negative deltas
            for (int j = 0; j < CH_N; j++) begin
               if (!diff[j][CH_W-1]) begin
                  qa_in[j] = signed'(CH_W'(dq_ff[j]));
                  ra_in[j] = dr_ff[j];
               end else if (dr_ff[j] == '0) begin
                  qa_in[j] = -signed'(CH_W'(dq_ff[j]));
                  ra_in[j] = '0;
               end else begin
                  qa_in[j] = -signed'(CH_W'(dq_ff[j])) - signed'(CH_W'(1));
                  ra_in[j] = n_ff - dr_ff[j];
               end
               pt_in[j] = prv_w[j];
               r_in[j]  = '0;
            end
            i_in     = '0;
            state_in = B_POINT;
         end
         B_POINT: begin
            if (slot_free) begin
               ov_in = 1'b1;
               for (int j = 0; j < POS_N; j++) begin
                  rsp_in.pt.pos[j] = pt_ff[j][POS_W-1:0];
               end
               for (int k = 0; k < COL_N; k++) begin
                  rsp_in.pt.col[k] = pt_ff[POS_N+k][COL_W-1:0];
               end
               rsp_in.run_end  = last_pt && !cmd_ff.fin;
               rsp_in.line_end = 1'b0;
               for (int j = 0; j < CH_N; j++) begin
                  r_sum = {1'b0, r_ff[j]} + {1'b0, ra_ff[j]};
                  if (r_sum >= {1'b0, n_ff}) begin
                     r_sum    = r_sum - {1'b0, n_ff};
                     pt_in[j] = pt_ff[j] + qa_ff[j] + signed'(CH_W'(1));
                  end else begin
                     pt_in[j] = pt_ff[j] + qa_ff[j];
                  end
                  r_in[j] = r_sum[NW-1:0];
               end
               i_in = i_ff + 1'b1;
               if (last_pt) begin
                  state_in = cmd_ff.fin ? B_VERTEX : B_IDLE;
               end
            end
         end
         B_VERTEX: begin
            if (slot_free) begin
               ov_in           = 1'b1;
               rsp_in.pt       = cmd_ff.cur;
               rsp_in.run_end  = 1'b1;
               rsp_in.line_end = cmd_ff.fin;
               state_in        = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      cmd_ff  <= cmd_in;
      n_ff    <= n_in;
      i_ff    <= i_in;
      dcnt_ff <= dcnt_in;
      dq_ff   <= dq_in;
      dr_ff   <= dr_in;
      qa_ff   <= qa_in;
      ra_ff   <= ra_in;
      pt_ff   <= pt_in;
      r_ff    <= r_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp       = rsp_ff;

   `ASSERT_IMPLIES(a_point_in_range, state_ff == B_POINT, (n_ff != '0) && (i_ff < n_ff),
      "point index outside segment")

endmodule

`default_nettype wire

// ===== rtl/polyline_density_resampler.sv =====
// polyline density resampler: vertex in, resampled points out
// vertex-only transaction (pass-through or one-vertex line): queue, back-end start and vertex states
// segment: the first point waits for the gap counter's multiply and bit-wise root search and for
// the divider; then 1 point/cycle while the result register is free or being popped
// up to two accepted transactions wait in the command queue; a full result register stalls the back
// synchronous active-high reset empties queue and result register, clears vertex, density 1.0
`default_nettype none

module polyline_density_resampler import rsmp_pkg::*; #(
   parameter int MAX_GAPS = 63
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input channel
   input  wire logic                     req_push,
   output logic                          req_full,
   input  wire logic signed [POS_W-1:0]  req_pos_x,
   input  wire logic signed [POS_W-1:0]  req_pos_y,
   input  wire logic signed [POS_W-1:0]  req_pos_z,
   input  wire logic [COL_W-1:0]         req_red,
   input  wire logic [COL_W-1:0]         req_green,
   input  wire logic [COL_W-1:0]         req_blue,
   input  wire logic [COL_W-1:0]         req_alpha,
   input  wire logic                     req_final_vertex,
   // result channel
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop,
   output logic signed [POS_W-1:0]       rsp_out_x,
   output logic signed [POS_W-1:0]       rsp_out_y,
   output logic signed [POS_W-1:0]       rsp_out_z,
   output logic [COL_W-1:0]              rsp_out_red,
   output logic [COL_W-1:0]              rsp_out_green,
   output logic [COL_W-1:0]              rsp_out_blue,
   output logic [COL_W-1:0]              rsp_out_alpha,
   output logic                          rsp_run_end,
   output logic                          rsp_line_end,
   // density register
   input  wire logic                     csr_we,
   input  wire logic [DENS_W-1:0]        csr_wdata
);

   // density, unsigned Q8.16 points per cm
   logic [DENS_W-1:0] density_ff, density_in;

   vertex_type vtx;
   cmd_type    front_cmd, q_head;
   logic       q_push, q_full, q_pop, q_empty;
   logic       rsp_valid;
   rsp_type    rsp;

   assign density_in = csr_we ? csr_wdata : density_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff <= DENSITY_RESET;
      end else begin
         density_ff <= density_in;
      end
   end

   // incoming vertex, positions first then colour channels
   always_comb begin
      vtx.pos[0] = req_pos_x;
      vtx.pos[1] = req_pos_y;
      vtx.pos[2] = req_pos_z;
      vtx.col[0] = req_red;
      vtx.col[1] = req_green;
      vtx.col[2] = req_blue;
      vtx.col[3] = req_alpha;
   end

   // front end classifies each transaction and tracks the previous vertex
   rsmp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (req_push),
      .q_full       (q_full),
      .vtx          (vtx),
      .fin          (req_final_vertex),
      .density_zero (density_ff == '0),
      .q_push       (q_push),
      .q_cmd        (front_cmd)
   );

   // decouples the two ends so the front keeps accepting during a long segment until the queue is full
   rsmp_cmdq u_cmdq (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (front_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_head),
      .empty (q_empty)
   );

   assign req_full = q_full;

   // back end produces the points into its result register
   rsmp_back #(
      .MAX_GAPS (MAX_GAPS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_cmd     (q_head),
      .q_pop     (q_pop),
      .density   (density_ff),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_empty     = !rsp_valid;
   assign rsp_out_x     = rsp.pt.pos[0];
   assign rsp_out_y     = rsp.pt.pos[1];
   assign rsp_out_z     = rsp.pt.pos[2];
   assign rsp_out_red   = rsp.pt.col[0];
   assign rsp_out_green = rsp.pt.col[1];
   assign rsp_out_blue  = rsp.pt.col[2];
   assign rsp_out_alpha = rsp.pt.col[3];
   assign rsp_run_end   = rsp.run_end;
   assign rsp_line_end  = rsp.line_end;

endmodule

`default_nettype wire

// ===== tb/sv/tb_polyline_density_resampler.sv =====
// self-checking testbench for polyline_density_resampler
// depends on rsmp_pkg (widths, density reset) and the resampler rtl
`timescale 1ns / 100ps
`default_nettype none

module tb_polyline_density_resampler;
   import rsmp_pkg::*;

   localparam int MAX_GAPS   = 63;
   localparam int SETTLE     = 200;   // covers a full segment with saturated point count
   localparam int QUIET_MAX  = 6000;  // cycles without any transaction before giving up
   localparam int HOLD_LONG  = 400;

   // one resampled point as it should appear on the result side
   typedef struct {
      logic signed [POS_W-1:0] x, y, z;
      logic [COL_W-1:0]        r, g, b, a;
      logic                    run_end;
      logic                    line_end;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [COL_W-1:0] req_red = '0, req_green = '0, req_blue = '0, req_alpha = '0;
   logic req_final_vertex = 1'b0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [POS_W-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic [COL_W-1:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic rsp_run_end, rsp_line_end;
   logic csr_we = 1'b0;
   logic [DENS_W-1:0] csr_wdata = '0;

   polyline_density_resampler #(.MAX_GAPS(MAX_GAPS)) dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the block's state
   logic signed [POS_W-1:0] held_pos [3];
   logic [COL_W-1:0]        held_col [4];
   logic                    held_valid;
   logic [DENS_W-1:0]       dens_shadow;

   point_type pending_points [$];
   int     mismatches = 0;
   int     quiet_cycles = 0;
   bit     timed_out = 0;
   bit     no_idle = 0;     // stretches with no gaps on either side
   int     hold_off = 0;    // receiver hold-off requested by a test

   // floor(a*i/n), rounding towards minus infinity
   function automatic longint floor_step(longint a, longint i, longint n);
      longint p, q;
      p = a * i;
      q = p / n;
      if ((p % n) != 0 && p < 0) q = q - 1;
      return q;
   endfunction

   // smallest n with n^2 * 2^64 >= S * density^2, saturated
   function automatic int gap_count(logic signed [POS_W-1:0] cur [3]);
      logic [127:0] sum_sq, prod, lhs;
      longint d;
      logic [63:0] mag;
      sum_sq = '0;
      for (int j = 0; j < 3; j++) begin
         d = longint'(cur[j]) - longint'(held_pos[j]);
         mag = (d < 0) ? -d : d;
         sum_sq = sum_sq + 128'(mag) * 128'(mag);
      end
      prod = sum_sq * (128'(dens_shadow) * 128'(dens_shadow));
      for (int n = 0; n < MAX_GAPS; n++) begin
         lhs = 128'(n * n) << 64;
         if (lhs >= prod) return n;
      end
      return MAX_GAPS;
   endfunction

   // works out every point one accepted vertex causes
   task automatic resample_vertex(logic signed [POS_W-1:0] pos [3], logic [COL_W-1:0] col [4],
                                  logic fin);
      point_type pt;
      int     n, first;
      longint a;
      first = pending_points.size();
      if (dens_shadow == 0) begin
         pt = '{pos[0], pos[1], pos[2], col[0], col[1], col[2], col[3], 1'b0, fin};
         pending_points = {pending_points, pt};
         held_pos = pos; held_col = col;
         held_valid = !fin;
      end else if (!held_valid) begin
         if (fin) begin
            pt = '{pos[0], pos[1], pos[2], col[0], col[1], col[2], col[3], 1'b0, 1'b1};
            pending_points = {pending_points, pt};
         end else begin
            held_pos = pos; held_col = col;
            held_valid = 1'b1;
         end
      end else begin
         n = gap_count(pos);
         for (int i = 0; i < n; i++) begin
            a = held_pos[0]; pt.x = POS_W'(a + floor_step(longint'(pos[0]) - a, i, n));
            a = held_pos[1]; pt.y = POS_W'(a + floor_step(longint'(pos[1]) - a, i, n));
            a = held_pos[2]; pt.z = POS_W'(a + floor_step(longint'(pos[2]) - a, i, n));
            a = held_col[0]; pt.r = COL_W'(a + floor_step(longint'(col[0]) - a, i, n));
            a = held_col[1]; pt.g = COL_W'(a + floor_step(longint'(col[1]) - a, i, n));
            a = held_col[2]; pt.b = COL_W'(a + floor_step(longint'(col[2]) - a, i, n));
            a = held_col[3]; pt.a = COL_W'(a + floor_step(longint'(col[3]) - a, i, n));
            pt.run_end = 1'b0; pt.line_end = 1'b0;
            pending_points = {pending_points, pt};
         end
         if (fin) begin
            pt = '{pos[0], pos[1], pos[2], col[0], col[1], col[2], col[3], 1'b0, 1'b1};
            pending_points = {pending_points, pt};
            held_valid = 1'b0;
         end
         held_pos = pos; held_col = col;
      end
      if (pending_points.size() > first)
         pending_points[pending_points.size()-1].run_end = 1'b1;
   endtask

   function automatic int pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(10, 40);
   endfunction

   // offers one vertex transaction and waits for it to be taken
   task automatic push_vertex(logic signed [POS_W-1:0] x, y, z,
                              logic [COL_W-1:0] r, g, b, a, logic fin);
      int gap;
      logic signed [POS_W-1:0] pos [3];
      logic [COL_W-1:0] col [4];
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_pos_x = x; req_pos_y = y; req_pos_z = z;
      req_red = r; req_green = g; req_blue = b; req_alpha = a;
      req_final_vertex = fin;
      req_push = 1'b1;
      do @(posedge clock); while (req_full);
      pos = '{x, y, z}; col = '{r, g, b, a};
      resample_vertex(pos, col, fin);
   endtask

   task automatic stop_pushing();
      @(negedge clock);
      req_push = 1'b0;
   endtask

   // waits until every expected point is out, plus the longest segment time
   task automatic drain();
      stop_pushing();
      while (pending_points.size() != 0 && !timed_out) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_density(logic [DENS_W-1:0] value);
      drain();
      @(negedge clock);
      csr_we = 1'b1; csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      dens_shadow = value;
   endtask

   // receiver: random pop, with a counted hold-off when a test asks for one
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_pop = 1'b0;
            hold_off--;
         end else if (no_idle) rsp_pop = 1'b1;
         else if ($urandom_range(0, 19) == 0) begin
            rsp_pop = 1'b0;
            repeat ($urandom_range(10, 40)) @(negedge clock);
         end else rsp_pop = ($urandom_range(0, 3) != 0);
      end
   end

   // result checker and watchdog
   always @(posedge clock) begin
      point_type want;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_pop && !rsp_empty) begin
            if (pending_points.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected point x=%h y=%h", rsp_out_x, rsp_out_y);
            end else begin
               want = pending_points.pop_front();
               if (rsp_out_x !== want.x || rsp_out_y !== want.y || rsp_out_z !== want.z ||
                   rsp_out_red !== want.r || rsp_out_green !== want.g ||
                   rsp_out_blue !== want.b || rsp_out_alpha !== want.a ||
                   rsp_run_end !== want.run_end || rsp_line_end !== want.line_end) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %h %h %h %h %h %h %h %b %b got %h %h %h %h %h %h %h %b %b",
                              want.x, want.y, want.z, want.r, want.g, want.b, want.a,
                              want.run_end, want.line_end, rsp_out_x, rsp_out_y, rsp_out_z,
                              rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha,
                              rsp_run_end, rsp_line_end);
               end
            end
         end
         if (quiet_cycles >= QUIET_MAX && !timed_out) begin
            timed_out = 1;
            $display("tb_polyline_density_resampler failed");
            $finish;
         end
      end
   end

   // extremes, exact ceiling, coincident vertices, saturation, one-vertex line
   task automatic test_directed();
      push_vertex(0, 0, 0, 0, 0, 0, 0, 0);
      push_vertex(32'sd196608, 32'sd262144, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0); // exactly 5 cm
      push_vertex(32'sd196608, 32'sd262144, 0, 1, 2, 3, 4, 0);               // coincident
      push_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);               // saturates
      push_vertex(-32'sh80000000, -32'sh80000000, -32'sh80000000, 0, 0, 0, 0, 1);
      push_vertex(32'sd12345, -32'sd999, 32'sd7, 16'h8000, 16'h7FFF, 1, 16'hFFFE, 1);
      push_vertex(0, 0, 0, 0, 0, 0, 0, 0);
      push_vertex(32'sd65537, 0, 0, 100, 200, 300, 400, 1);                  // just past 1 cm
      write_density(24'hFFFFFF);
      push_vertex(0, 0, 0, 0, 0, 0, 0, 0);
      push_vertex(1, 1, 1, 16'hFFFF, 0, 0, 16'hFFFF, 0);
      push_vertex(-32'sd300, 32'sd5, 0, 0, 16'hFFFF, 0, 0, 1);
      write_density('0);
      push_vertex(32'sh7FFFFFFF, -32'sh80000000, 0, 16'hFFFF, 0, 16'hFFFF, 0, 0);
      push_vertex(5, 6, 7, 8, 9, 10, 11, 1);
      push_vertex(-1, -1, -1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      write_density(24'd1);  // change mid-polyline: passed vertex starts the next segment
      push_vertex(32'sh40000000, 0, 0, 0, 0, 0, 0, 1);
   endtask

   function automatic logic signed [POS_W-1:0] rand_step(logic signed [POS_W-1:0] base);
      int unsigned kind;
      kind = $urandom_range(0, 9);
      if (kind < 7) return base + $signed($urandom_range(0, 524288)) - 262144;
      if (kind < 9) return base + $signed($urandom_range(0, 200)) - 100;
      return $urandom;
   endfunction

   // well-formed polylines with random content, a little noise on the final mark
   task automatic test_random_lines(int count);
      int sent, len;
      logic signed [POS_W-1:0] x, y, z;
      sent = 0;
      while (sent < count) begin
         len = $urandom_range(1, 8);
         x = $urandom; y = $urandom; z = $urandom;
         for (int k = 0; k < len; k++) begin
            x = rand_step(x); y = rand_step(y); z = rand_step(z);
            push_vertex(x, y, z, COL_W'($urandom), COL_W'($urandom), COL_W'($urandom),
                        COL_W'($urandom),
                        (k == len - 1) || ($urandom_range(0, 19) == 0));
            sent++;
         end
      end
   endtask

   // receiver holds off while pass-through vertices keep coming, filling the block
   task automatic test_full_stall();
      write_density('0);
      @(negedge clock);
      hold_off = HOLD_LONG;
      for (int k = 0; k < 30; k++)
         push_vertex($urandom, $urandom, $urandom, COL_W'($urandom), COL_W'($urandom),
                     COL_W'($urandom), COL_W'($urandom), 1'($urandom_range(0, 1)));
   endtask

   initial begin
      held_pos = '{0, 0, 0}; held_col = '{0, 0, 0, 0};
      held_valid = 1'b0;
      dens_shadow = DENSITY_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      write_density(DENSITY_RESET);
      test_random_lines(70);
      no_idle = 1;
      write_density(24'd16384);
      test_random_lines(50);
      no_idle = 0;
      write_density(DENS_W'($urandom_range(1, 24'hFFFFFF)));
      test_random_lines(50);
      write_density('0);
      test_random_lines(50);
      write_density(24'd1);
      test_random_lines(40);
      write_density(24'hFFFFFF);
      test_random_lines(30);
      test_full_stall();
      drain();

      if (mismatches == 0 && pending_points.size() == 0)
         $display("tb_polyline_density_resampler passed");
      else
         $display("tb_polyline_density_resampler failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/rsmp_pkg.sv
rtl/rsmp_front.sv
rtl/rsmp_cmdq.sv
rtl/rsmp_gap.sv
rtl/rsmp_back.sv
rtl/polyline_density_resampler.sv
tb/sv/tb_polyline_density_resampler.sv
